>>> rtl/core/ipsp_pkg.sv
package ipsp_pkg;

    localparam int BYTE_W     = 8;
    localparam int SKIP_W     = 24;
    localparam int ADDR_W     = 25;
    localparam int LEN_W      = 16;
    localparam int KIND_W     = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [SKIP_W-1:0] DEFAULT_HEADER_SKIP = 24'd512;
    localparam logic [SKIP_W-1:0] EOF_WORD            = 24'h454F46;

    localparam logic [KIND_W-1:0] KIND_DATA       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FILL       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PATCH_END  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NOT_IPS    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UNEXPECTED = 3'd4;

    typedef struct packed {
        logic              prim_valid;
        logic [KIND_W-1:0] prim_kind;
        logic [ADDR_W-1:0] prim_addr;
        logic [LEN_W-1:0]  prim_len;
        logic [BYTE_W-1:0] prim_value;
        logic              end_valid;
        logic [KIND_W-1:0] end_kind;
    } t_queue_entry;

    function automatic logic [BYTE_W-1:0] header_byte(input logic [2:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            3'd0:    b = 8'h50;
            3'd1:    b = 8'h41;
            3'd2:    b = 8'h54;
            3'd3:    b = 8'h43;
            3'd4:    b = 8'h48;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/core/ipsp_if.sv
interface ipsp_in_if;
    import ipsp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] patch_byte;
    logic              stream_end;

    modport source (output valid, output patch_byte, output stream_end, input ready);
    modport sink   (input valid, input patch_byte, input stream_end, output ready);
endinterface

interface ipsp_out_if;
    import ipsp_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] target_address;
    logic [LEN_W-1:0]  run_length;
    logic [BYTE_W-1:0] value;
    logic              last_of_run;

    modport source (output valid, output kind, output target_address, output run_length,
                    output value, output last_of_run, input ready);
    modport sink   (input valid, input kind, input target_address, input run_length,
                    input value, input last_of_run, output ready);
endinterface

interface ipsp_cfg_if;
    import ipsp_pkg::*;

    logic              valid;
    logic              ready;
    logic [SKIP_W-1:0] header_skip;

    modport source (output valid, output header_skip, input ready);
    modport sink   (input valid, input header_skip, output ready);
endinterface

>>> rtl/core/ipsp_front.sv
module ipsp_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ipsp_in_if.sink               i_in,
    ipsp_cfg_if.sink              i_cfg,
    input  logic                  i_full,
    output logic                  o_push,
    output ipsp_pkg::t_queue_entry o_push_data
);
    import ipsp_pkg::*;

    localparam logic [2:0] PH_HEADER   = 3'd0;
    localparam logic [2:0] PH_OFFSET   = 3'd1;
    localparam logic [2:0] PH_SIZE     = 3'd2;
    localparam logic [2:0] PH_DATA     = 3'd3;
    localparam logic [2:0] PH_FILL_LEN = 3'd4;
    localparam logic [2:0] PH_FILL_VAL = 3'd5;
    localparam logic [2:0] PH_IDLE     = 3'd6;

    logic [2:0]        r_phase, n_phase;
    logic [2:0]        r_count, n_count;
    logic [SKIP_W-1:0] r_offset, n_offset;
    logic [LEN_W-1:0]  r_size, n_size;
    logic [LEN_W-1:0]  r_remain, n_remain;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_dropped, n_dropped;
    logic [SKIP_W-1:0] r_skip;

    logic              accept;
    logic              terminal;
    logic [2:0]        hdr_idx;
    logic [2:0]        cnt_inc;
    logic [SKIP_W-1:0] off_full;
    logic [LEN_W-1:0]  size_full;
    logic [LEN_W-1:0]  remain_dec;
    logic [ADDR_W-1:0] skip_diff;
    t_queue_entry      entry;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_full;
    assign accept      = i_in.valid && !i_full;

    assign hdr_idx    = (r_count > 3'd4) ? 3'd0 : r_count;
    assign cnt_inc    = r_count + 3'd1;
    assign off_full   = {r_offset[SKIP_W-9:0], i_in.patch_byte};
    assign size_full  = {r_size[LEN_W-9:0], i_in.patch_byte};
    assign remain_dec = r_remain - 16'd1;
    assign skip_diff  = {1'b0, off_full} - {1'b0, r_skip};

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_offset  = r_offset;
        n_size    = r_size;
        n_remain  = r_remain;
        n_addr    = r_addr;
        n_dropped = r_dropped;
        terminal  = 1'b0;
        entry     = '0;
        entry.prim_kind = KIND_DATA;
        entry.end_kind  = KIND_UNEXPECTED;

        case (r_phase)
            PH_HEADER: begin
                n_count = hdr_idx;
                if (i_in.patch_byte != header_byte(hdr_idx)) begin
                    entry.prim_valid = 1'b1;
                    entry.prim_kind  = KIND_NOT_IPS;
                    terminal         = 1'b1;
                    n_phase          = PH_IDLE;
                end else if (hdr_idx == 3'd4) begin
                    n_count = 3'd0;
                    n_phase = PH_OFFSET;
                end else begin
                    n_count = hdr_idx + 3'd1;
                end
            end
            PH_OFFSET: begin
                n_offset = off_full;
                n_count  = cnt_inc;
                if (cnt_inc >= 3'd3) begin
                    n_count = 3'd0;
                    if (off_full == EOF_WORD) begin
                        entry.prim_valid = 1'b1;
                        entry.prim_kind  = KIND_PATCH_END;
                        terminal         = 1'b1;
                        n_phase          = PH_IDLE;
                    end else begin
                        n_dropped = skip_diff[ADDR_W-1];
                        n_addr    = skip_diff[ADDR_W-1] ? '0 : {1'b0, skip_diff[SKIP_W-1:0]};
                        n_size    = '0;
                        n_phase   = PH_SIZE;
                    end
                end
            end
            PH_SIZE: begin
                n_size  = size_full;
                n_count = cnt_inc;
                if (cnt_inc >= 3'd2) begin
                    n_count  = 3'd0;
                    n_remain = size_full;
                    n_phase  = (size_full == '0) ? PH_FILL_LEN : PH_DATA;
                end
            end
            PH_DATA: begin
                if (!r_dropped) begin
                    entry.prim_valid = 1'b1;
                    entry.prim_kind  = KIND_DATA;
                    entry.prim_addr  = r_addr;
                    entry.prim_value = i_in.patch_byte;
                end
                n_addr   = r_addr + 25'd1;
                n_remain = remain_dec;
                if (remain_dec == '0) begin
                    n_offset = '0;
                    n_phase  = PH_OFFSET;
                end
            end
            PH_FILL_LEN: begin
                n_remain = {r_remain[LEN_W-9:0], i_in.patch_byte};
                n_count  = cnt_inc;
                if (cnt_inc >= 3'd2) begin
                    n_count = 3'd0;
                    n_phase = PH_FILL_VAL;
                end
            end
            PH_FILL_VAL: begin
                if (!r_dropped) begin
                    entry.prim_valid = 1'b1;
                    entry.prim_kind  = KIND_FILL;
                    entry.prim_addr  = r_addr;
                    entry.prim_len   = r_remain;
                    entry.prim_value = i_in.patch_byte;
                end
                n_offset = '0;
                n_phase  = PH_OFFSET;
            end
            default: begin
                terminal = 1'b1;
                n_phase  = PH_IDLE;
            end
        endcase

        if (i_in.stream_end) begin
            entry.end_valid = !terminal;
            entry.end_kind  = (n_phase == PH_HEADER) ? KIND_NOT_IPS : KIND_UNEXPECTED;
            n_phase   = PH_HEADER;
            n_count   = '0;
            n_offset  = '0;
            n_size    = '0;
            n_remain  = '0;
            n_addr    = '0;
            n_dropped = 1'b0;
        end
    end

    assign o_push      = accept && (entry.prim_valid || entry.end_valid);
    assign o_push_data = entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_count   <= '0;
            r_offset  <= '0;
            r_size    <= '0;
            r_remain  <= '0;
            r_addr    <= '0;
            r_dropped <= 1'b0;
            r_skip    <= DEFAULT_HEADER_SKIP;
        end else begin
            if (accept) begin
                r_phase   <= n_phase;
                r_count   <= n_count;
                r_offset  <= n_offset;
                r_size    <= n_size;
                r_remain  <= n_remain;
                r_addr    <= n_addr;
                r_dropped <= n_dropped;
            end
            if (i_cfg.valid) begin
                r_skip <= i_cfg.header_skip;
            end
        end
    end

endmodule

>>> rtl/core/ipsp_queue.sv
module ipsp_queue #(
    parameter int DEPTH = ipsp_pkg::QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  ipsp_pkg::t_queue_entry i_push_data,
    output logic                   o_full,
    input  logic                   i_pop,
    output ipsp_pkg::t_queue_entry o_head,
    output logic                   o_empty
);
    import ipsp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_queue_entry     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/core/ipsp_back.sv
module ipsp_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_empty,
    input  ipsp_pkg::t_queue_entry i_head,
    output logic                   o_pop,
    ipsp_out_if.source             o_out
);
    import ipsp_pkg::*;

    logic              r_valid;
    logic [KIND_W-1:0] r_kind;
    logic [ADDR_W-1:0] r_addr;
    logic [LEN_W-1:0]  r_len;
    logic [BYTE_W-1:0] r_value;
    logic              r_last;
    logic              r_sec_pending;
    logic [KIND_W-1:0] r_sec_kind;
    logic              can_load;

    assign can_load = !r_valid || o_out.ready;
    assign o_pop    = can_load && !r_sec_pending && !i_empty;

    assign o_out.valid          = r_valid;
    assign o_out.kind           = r_kind;
    assign o_out.target_address = r_addr;
    assign o_out.run_length     = r_len;
    assign o_out.value          = r_value;
    assign o_out.last_of_run    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_sec_pending <= 1'b0;
        end else if (can_load) begin
            if (r_sec_pending) begin
                r_valid       <= 1'b1;
                r_sec_pending <= 1'b0;
            end else if (!i_empty) begin
                r_valid       <= 1'b1;
                r_sec_pending <= i_head.prim_valid && i_head.end_valid;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_load) begin
            if (r_sec_pending) begin
                r_kind  <= r_sec_kind;
                r_addr  <= '0;
                r_len   <= '0;
                r_value <= '0;
                r_last  <= 1'b1;
            end else if (i_head.prim_valid) begin
                r_kind     <= i_head.prim_kind;
                r_addr     <= i_head.prim_addr;
                r_len      <= i_head.prim_len;
                r_value    <= i_head.prim_value;
                r_last     <= !i_head.end_valid;
                r_sec_kind <= i_head.end_kind;
            end else begin
                r_kind  <= i_head.end_kind;
                r_addr  <= '0;
                r_len   <= '0;
                r_value <= '0;
                r_last  <= 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/ips_patch_stream_parser.sv
// ips patch stream parser
// i_in carries the patch file one byte per transaction, with stream_end on the
// last byte. o_out carries results: data bytes with their rebased target
// address, fill run descriptors, and patch end / not ips / unexpected end
// status. last_of_run marks the final result caused by one input byte.
// i_cfg writes header_skip; write it only while the parser is idle.
// a byte is taken every cycle while the result queue has room. its first
// result is registered in the queue and then in the output register. a byte
// that causes two results (a result followed by an end status) holds the
// output register for both before the next queue entry is taken; the output
// register emits one result per cycle while the receiver holds o_out.ready high.
// the front parser and the output stage are split by a queue of QUEUE_DEPTH
// entries; when the receiver stalls the queue fills and then i_in.ready drops.
// bytes that cause no result never enter the queue.
// reset restores header_skip to 512, expects a new PATCH header and empties
// the queue. every byte marked stream_end also rearms the header check.
module ips_patch_stream_parser #(
    parameter int QUEUE_DEPTH = ipsp_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ipsp_in_if.sink    i_in,
    ipsp_cfg_if.sink   i_cfg,
    ipsp_out_if.source o_out
);
    import ipsp_pkg::*;

    logic         push, pop, full, empty;
    t_queue_entry push_data, head;

    ipsp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (i_cfg),
        .i_full      (full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    ipsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .i_pop       (pop),
        .o_head      (head),
        .o_empty     (empty)
    );

    ipsp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import ipsp_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int MAX_GAP       = 10;
    localparam int HOLD_CYCLES   = 120;
    localparam int DRAIN_CYCLES  = 8;
    localparam int END_CYCLES    = 20;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 1550;
    localparam int N_SEGMENTS    = 5;
    localparam int N_DIRECTED    = 26;
    localparam int MIN_FIRST_FILE = 64;

    localparam logic [BYTE_W-1:0] PATCH_MAGIC [5] = '{8'h50, 8'h41, 8'h54, 8'h43, 8'h48};

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_OFFSET,
        PH_SIZE,
        PH_DATA,
        PH_FILL_LEN,
        PH_FILL_VAL,
        PH_IDLE
    } t_parse_phase;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] value;
        logic              last;
    } t_patch_result;

    typedef struct packed {
        logic [BYTE_W-1:0] b;
        logic              fin;
        logic              typed;
        logic [KIND_W-1:0] kind;
    } t_directed_row;

    // bad first byte, ignored tail, short header, one data record,
    // zero-length fill at the top offset, orderly end, ignored tail
    localparam t_directed_row DIRECTED [N_DIRECTED] = '{
        '{8'h00, 1'b0, 1'b1, KIND_NOT_IPS},
        '{8'hFF, 1'b1, 1'b0, KIND_DATA},
        '{8'h50, 1'b1, 1'b1, KIND_NOT_IPS},
        '{8'h50, 1'b0, 1'b0, KIND_DATA},
        '{8'h41, 1'b0, 1'b0, KIND_DATA},
        '{8'h54, 1'b0, 1'b0, KIND_DATA},
        '{8'h43, 1'b0, 1'b0, KIND_DATA},
        '{8'h48, 1'b0, 1'b0, KIND_DATA},
        '{8'h00, 1'b0, 1'b0, KIND_DATA},
        '{8'h02, 1'b0, 1'b0, KIND_DATA},
        '{8'h00, 1'b0, 1'b0, KIND_DATA},
        '{8'h00, 1'b0, 1'b0, KIND_DATA},
        '{8'h01, 1'b0, 1'b0, KIND_DATA},
        '{8'hFF, 1'b0, 1'b0, KIND_DATA},
        '{8'hFF, 1'b0, 1'b0, KIND_DATA},
        '{8'hFF, 1'b0, 1'b0, KIND_DATA},
        '{8'hFF, 1'b0, 1'b0, KIND_DATA},
        '{8'h00, 1'b0, 1'b0, KIND_DATA},
        '{8'h00, 1'b0, 1'b0, KIND_DATA},
        '{8'h00, 1'b0, 1'b0, KIND_DATA},
        '{8'h00, 1'b0, 1'b0, KIND_DATA},
        '{8'h55, 1'b0, 1'b0, KIND_DATA},
        '{8'h45, 1'b0, 1'b0, KIND_DATA},
        '{8'h4F, 1'b0, 1'b0, KIND_DATA},
        '{8'h46, 1'b0, 1'b1, KIND_PATCH_END},
        '{8'h00, 1'b1, 1'b0, KIND_DATA}
    };

    logic i_clk;
    logic i_rst_n;

    ipsp_in_if  in_if();
    ipsp_cfg_if cfg_if();
    ipsp_out_if out_if();

    ips_patch_stream_parser u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    t_patch_result     expected_results[$];
    t_patch_result     step_results[$];
    logic [BYTE_W-1:0] file_bytes[$];

    // parser state mirror
    logic [SKIP_W-1:0] skip_model;
    t_parse_phase      ph;
    logic [2:0]        field_cnt;
    logic [SKIP_W-1:0] rec_offset;
    logic [LEN_W-1:0]  rec_size;
    logic [LEN_W-1:0]  bytes_left;
    logic [ADDR_W-1:0] next_addr;
    logic              rec_dropped;

    int mismatch_count = 0;
    int parsed_bytes;
    int idle_cycles = 0;
    bit burst_mode;
    bit hold_req;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic void clear_parse_state();
        ph          = PH_HEADER;
        field_cnt   = '0;
        rec_offset  = '0;
        rec_size    = '0;
        bytes_left  = '0;
        next_addr   = '0;
        rec_dropped = 1'b0;
    endfunction

    function automatic void add_result(input logic [KIND_W-1:0] kind,
                                       input logic [ADDR_W-1:0] addr,
                                       input logic [LEN_W-1:0] len,
                                       input logic [BYTE_W-1:0] value);
        t_patch_result r;
        r = '{kind: kind, addr: addr, len: len, value: value, last: 1'b0};
        step_results.push_back(r);
    endfunction

    function automatic void predict_patch_byte(input logic [BYTE_W-1:0] b, input logic fin,
                                               output bit ignored);
        bit terminal;
        terminal = 1'b0;
        step_results.delete();
        ignored = (ph == PH_IDLE);
        case (ph)
            PH_HEADER: begin
                if (field_cnt > 3'd4) field_cnt = '0;
                if (b != PATCH_MAGIC[field_cnt]) begin
                    add_result(KIND_NOT_IPS, '0, '0, '0);
                    terminal = 1'b1;
                    ph = PH_IDLE;
                end else begin
                    field_cnt = field_cnt + 3'd1;
                    if (field_cnt >= 3'd5) begin
                        field_cnt = '0;
                        ph = PH_OFFSET;
                    end
                end
            end
            PH_OFFSET: begin
                rec_offset = {rec_offset[15:0], b};
                field_cnt = field_cnt + 3'd1;
                if (field_cnt >= 3'd3) begin
                    field_cnt = '0;
                    if (rec_offset == EOF_WORD) begin
                        add_result(KIND_PATCH_END, '0, '0, '0);
                        terminal = 1'b1;
                        ph = PH_IDLE;
                    end else begin
                        rec_dropped = (rec_offset < skip_model);
                        next_addr = rec_dropped ? '0 : ({1'b0, rec_offset} - {1'b0, skip_model});
                        rec_size = '0;
                        ph = PH_SIZE;
                    end
                end
            end
            PH_SIZE: begin
                rec_size = {rec_size[7:0], b};
                field_cnt = field_cnt + 3'd1;
                if (field_cnt >= 3'd2) begin
                    field_cnt = '0;
                    bytes_left = rec_size;
                    ph = (rec_size == '0) ? PH_FILL_LEN : PH_DATA;
                end
            end
            PH_DATA: begin
                if (!rec_dropped) add_result(KIND_DATA, next_addr, '0, b);
                next_addr = next_addr + 1'b1;
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == '0) begin
                    rec_offset = '0;
                    ph = PH_OFFSET;
                end
            end
            PH_FILL_LEN: begin
                bytes_left = {bytes_left[7:0], b};
                field_cnt = field_cnt + 3'd1;
                if (field_cnt >= 3'd2) begin
                    field_cnt = '0;
                    ph = PH_FILL_VAL;
                end
            end
            PH_FILL_VAL: begin
                if (!rec_dropped) add_result(KIND_FILL, next_addr, bytes_left, b);
                rec_offset = '0;
                ph = PH_OFFSET;
            end
            default: begin
                terminal = 1'b1;
                ph = PH_IDLE;
            end
        endcase
        if (fin) begin
            if (!terminal) add_result((ph == PH_HEADER) ? KIND_NOT_IPS : KIND_UNEXPECTED,
                                      '0, '0, '0);
            clear_parse_state();
        end
        if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
    endfunction

    task automatic send_patch_byte(input logic [BYTE_W-1:0] b, input logic fin,
                                   input logic typed, input logic [KIND_W-1:0] tkind);
        int gap;
        bit ignored;
        t_patch_result r;
        gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.patch_byte <= b;
        in_if.stream_end <= fin;
        do @(posedge i_clk); while (!in_if.ready);
        predict_patch_byte(b, fin, ignored);
        if (!ignored) parsed_bytes++;
        if (typed) begin
            r = '{kind: tkind, addr: '0, len: '0, value: '0, last: 1'b1};
            expected_results.push_back(r);
        end else begin
            foreach (step_results[i]) expected_results.push_back(step_results[i]);
        end
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_header_skip(input logic [SKIP_W-1:0] v);
        wait_drained();
        cfg_if.valid       <= 1'b1;
        cfg_if.header_skip <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        skip_model = v;
    endtask

    function automatic void push_word24(input logic [SKIP_W-1:0] w);
        file_bytes.push_back(w[23:16]);
        file_bytes.push_back(w[15:8]);
        file_bytes.push_back(w[7:0]);
    endfunction

    function automatic logic [SKIP_W-1:0] pick_offset();
        logic [SKIP_W-1:0] off;
        case ($urandom_range(0, 5))
            0:       off = skip_model - SKIP_W'($urandom_range(1, 64));
            1:       off = skip_model;
            2:       off = skip_model + SKIP_W'($urandom_range(1, 4096));
            3:       off = 24'hFFFFFF;
            4:       off = SKIP_W'($urandom());
            default: off = skip_model + SKIP_W'($urandom_range(0, 255));
        endcase
        if (off == EOF_WORD) off = off ^ 24'h1;
        return off;
    endfunction

    function automatic void build_patch_file();
        int n_rec;
        int n_data;
        logic [LEN_W-1:0] len;
        file_bytes.delete();
        foreach (PATCH_MAGIC[i]) file_bytes.push_back(PATCH_MAGIC[i]);
        n_rec = $urandom_range(1, 5);
        repeat (n_rec) begin
            push_word24(pick_offset());
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0:       len = 16'h0000;
                    1:       len = 16'hFFFF;
                    2:       len = LEN_W'($urandom());
                    default: len = LEN_W'($urandom_range(1, 16));
                endcase
                file_bytes.push_back(8'h00);
                file_bytes.push_back(8'h00);
                file_bytes.push_back(len[15:8]);
                file_bytes.push_back(len[7:0]);
                file_bytes.push_back(BYTE_W'($urandom()));
            end else begin
                n_data = ($urandom_range(0, 14) == 0) ? $urandom_range(13, 64)
                                                      : $urandom_range(1, 12);
                file_bytes.push_back(8'h00);
                file_bytes.push_back(BYTE_W'(n_data));
                repeat (n_data) file_bytes.push_back(BYTE_W'($urandom()));
            end
        end
        push_word24(EOF_WORD);
        repeat ($urandom_range(0, 2)) file_bytes.push_back(BYTE_W'($urandom()));
    endfunction

    // result side: random stalls, one long hold-off on request
    initial begin
        int stall;
        bit hold_done;
        t_patch_result got;
        t_patch_result want;
        hold_done = 1'b0;
        out_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req && !hold_done) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            stall = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            got = '{kind: out_if.kind, addr: out_if.target_address, len: out_if.run_length,
                    value: out_if.value, last: out_if.last_of_run};
            if (expected_results.size() == 0) begin
                mismatch_count++;
                $display("%0t unexpected transaction: kind=%0d addr=%h len=%h value=%h last=%0b",
                         $time, got.kind, got.addr, got.len, got.value, got.last);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    $display("%0t mismatch: expected kind=%0d addr=%h len=%h value=%h last=%0b",
                             $time, want.kind, want.addr, want.len, want.value, want.last);
                    $display("%0t           actual   kind=%0d addr=%h len=%h value=%h last=%0b",
                             $time, got.kind, got.addr, got.len, got.value, got.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int r;
        int n;
        int idx;
        bit first_file;
        logic [SKIP_W-1:0] skip_val;
        parsed_bytes       = 0;
        burst_mode         = 1'b0;
        hold_req           = 1'b0;
        skip_model         = DEFAULT_HEADER_SKIP;
        clear_parse_state();
        in_if.valid        <= 1'b0;
        in_if.patch_byte   <= '0;
        in_if.stream_end   <= 1'b0;
        cfg_if.valid       <= 1'b0;
        cfg_if.header_skip <= '0;
        i_rst_n            <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i])
            send_patch_byte(DIRECTED[i].b, DIRECTED[i].fin, DIRECTED[i].typed, DIRECTED[i].kind);

        parsed_bytes = 0;
        first_file = 1'b1;
        for (int seg = 0; seg < N_SEGMENTS; seg++) begin
            case (seg)
                0:       skip_val = 24'h000000;
                1:       skip_val = 24'hFFFFFF;
                2:       skip_val = SKIP_W'($urandom_range(1, 4096));
                3:       skip_val = SKIP_W'($urandom());
                default: skip_val = DEFAULT_HEADER_SKIP;
            endcase
            write_header_skip(skip_val);
            while (parsed_bytes < (seg + 1) * RANDOM_ITEMS / N_SEGMENTS) begin
                r = first_file ? 0 : $urandom_range(0, 99);
                burst_mode = first_file || ($urandom_range(0, 5) == 0);
                // long result-side hold-off while bytes keep coming
                if (first_file) hold_req = 1'b1;
                // first file long enough to fill the queue during the hold-off
                do build_patch_file(); while (first_file && file_bytes.size() < MIN_FIRST_FILE);
                first_file = 1'b0;
                if (r >= 75 && r < 87) begin
                    n = $urandom_range(1, file_bytes.size() - 1);
                    while (file_bytes.size() > n) void'(file_bytes.pop_back());
                end else if (r >= 87 && r < 94) begin
                    idx = $urandom_range(0, 4);
                    file_bytes[idx] = file_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
                end else if (r >= 94) begin
                    file_bytes.delete();
                    repeat ($urandom_range(1, 6)) file_bytes.push_back(BYTE_W'($urandom()));
                end
                foreach (file_bytes[i])
                    send_patch_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b0, KIND_DATA);
            end
        end
        burst_mode = 1'b0;

        wait_drained();
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/ipsp_pkg.sv
rtl/core/ipsp_if.sv
rtl/core/ipsp_front.sv
rtl/core/ipsp_queue.sv
rtl/core/ipsp_back.sv
rtl/core/ips_patch_stream_parser.sv
tb/tb.sv
